[design/pmc_pkg.sv]
// Package for the IPv6 path MTU cache: field widths, commands, status codes,
// packed request and result types. No dependencies.
package pmc_pkg;

  localparam int unsigned DefEntries  = 8;
  localparam int unsigned DefIfaces   = 16;
  localparam int unsigned IfaceW      = 4;
  localparam int unsigned MinLinkMtu  = 1280;
  localparam int unsigned HeaderLen   = 40;
  localparam logic [30:0] TimeoutRst  = 31'd600000;
  localparam logic [31:0] NoWake      = 32'hffffffff;
  localparam int unsigned InDataW     = 360;
  localparam int unsigned OutDataW    = 56;

  typedef enum logic [2:0] {
    CMD_TRACK  = 3'd0,
    CMD_PTB    = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_DROP   = 3'd3,
    CMD_SWEEP  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IGNORED   = 3'd0,
    ST_NEW_SLOT  = 3'd1,
    ST_REFRESHED = 3'd2,
    ST_KNOWN     = 3'd3,
    ST_NO_SLOT   = 3'd4,
    ST_LEARNED   = 3'd5,
    ST_UNMATCHED = 3'd6,
    ST_DONE      = 3'd7
  } status_t;

  // classified request handed from the front part to the back part
  typedef struct packed {
    logic [2:0]  command;
    logic        drop;
    logic [3:0]  iface;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [31:0] now_ms;
    logic [31:0] mtu_value;
  } req_t;

  typedef struct packed {
    logic [30:0] wake_delay_ms;
    logic        wake_valid;
    logic [15:0] path_mtu;
    logic [2:0]  status;
  } res_t;

endpackage

[design/pmc_front.sv]
// Front part of the path MTU cache: accepts requests, applies the range and
// RFC 8201 checks and queues classified requests. Depends on pmc_pkg.
module pmc_front #(
  parameter int unsigned NUM_IFACES = pmc_pkg::DefIfaces,
  parameter int unsigned QDEPTH     = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pmc_pkg::InDataW-1:0]   in_tdata,
  output logic                          q_valid,
  input  logic                          q_take,
  output pmc_pkg::req_t                 q_req
);

  logic [2:0]  cmd;
  logic [3:0]  ifc;
  logic [31:0] mval;
  logic [15:0] link, plen;
  logic        reply_ok, bad;
  logic [16:0] lim;
  pmc_pkg::req_t req;

  pmc_pkg::req_t q_r [QDEPTH];
  logic [$clog2(QDEPTH+1)-1:0] cnt_r, cnt_nxt;
  logic [$clog2(QDEPTH)-1:0] rd_r, wr_r;
  logic push;

  assign cmd      = in_tdata[2:0];
  assign ifc      = in_tdata[6:3];
  assign mval     = in_tdata[326:295];
  assign link     = in_tdata[342:327];
  assign plen     = in_tdata[358:343];
  assign reply_ok = in_tdata[359];
  assign lim      = {1'b0, plen} + 17'(pmc_pkg::HeaderLen);

  always_comb begin
    bad = 1'b0;
    if (cmd inside {3'd0, 3'd1, 3'd2, 3'd3} && 32'(ifc) >= NUM_IFACES) begin
      bad = 1'b1;
    end
    case (cmd)
      pmc_pkg::CMD_TRACK: begin
        if (link < 16'(pmc_pkg::MinLinkMtu) ||
            (in_tdata[70:7] == '0 && in_tdata[134:71] == '0) ||
            in_tdata[70:63] == 8'hff) bad = 1'b1;
      end
      pmc_pkg::CMD_PTB: begin
        if (mval < 32'(pmc_pkg::MinLinkMtu) || mval >= {16'd0, link} ||
            mval >= {15'd0, lim} || !reply_ok) bad = 1'b1;
      end
      default: ;
    endcase
    req.command   = cmd;
    req.drop      = bad;
    req.iface     = ifc;
    req.src_hi    = in_tdata[70:7];
    req.src_lo    = in_tdata[134:71];
    req.dst_hi    = in_tdata[198:135];
    req.dst_lo    = in_tdata[262:199];
    req.now_ms    = in_tdata[294:263];
    req.mtu_value = mval;
  end

  assign in_tready = (cnt_r != QDEPTH[$bits(cnt_r)-1:0]);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_req     = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_take && q_valid)) cnt_nxt = cnt_r + 1'b1;
    else if (!push && q_take && q_valid) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
      wr_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= wr_r + 1'b1;
      if (q_take && q_valid) rd_r <= rd_r + 1'b1;
    end
    if (push) q_r[wr_r] <= req;
  end

endmodule

[design/pmc_back.sv]
// Back part of the path MTU cache: entry table, match, selection, update,
// sweep and result register. Depends on pmc_pkg.
module pmc_back #(
  parameter int unsigned ENTRIES = pmc_pkg::DefEntries
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [30:0]         timeout_ms,
  input  logic                q_valid,
  output logic                q_take,
  input  pmc_pkg::req_t       q_req,
  output logic                out_tvalid,
  input  logic                out_tready,
  output pmc_pkg::res_t       out_res
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_APPLY, S_SWEEP} state_t;

  state_t state_r;
  pmc_pkg::req_t req_r;
  logic [ENTRIES-1:0] valid_r;
  logic [3:0]  e_if_r  [ENTRIES];
  logic [63:0] e_sh_r  [ENTRIES];
  logic [63:0] e_sl_r  [ENTRIES];
  logic [63:0] e_dh_r  [ENTRIES];
  logic [63:0] e_dl_r  [ENTRIES];
  logic [31:0] e_st_r  [ENTRIES];
  logic [15:0] e_mtu_r [ENTRIES];

  logic [ENTRIES-1:0] live_r, path_r, dst_r, ifm_r;
  logic [31:0] age_r [ENTRIES];
  pmc_pkg::res_t res_r;

  logic [31:0] age_c [ENTRIES];
  logic [ENTRIES-1:0] live_c, path_c, dst_c, ifm_c;

  logic         tr_hit, tr_sel_ok;
  logic [IW-1:0] tr_hit_i, tr_sel_i, pt_i;
  logic         pt_hit;
  logic [15:0]  best;
  logic [31:0]  oldest;
  logic [31:0]  next;
  logic [31:0]  left;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      age_c[i]  = req_r.now_ms - e_st_r[i];
      live_c[i] = valid_r[i] && (age_c[i] < {1'b0, timeout_ms});
      ifm_c[i]  = e_if_r[i] == req_r.iface;
      dst_c[i]  = ifm_c[i] && e_dh_r[i] == req_r.dst_hi && e_dl_r[i] == req_r.dst_lo;
      path_c[i] = dst_c[i] && e_sh_r[i] == req_r.src_hi && e_sl_r[i] == req_r.src_lo;
    end
  end

  // selection on registered match vectors
  always_comb begin
    tr_hit = 1'b0; tr_hit_i = '0; tr_sel_ok = 1'b0; tr_sel_i = '0; oldest = '0;
    pt_hit = 1'b0; pt_i = '0;
    best = (req_r.mtu_value > 32'hffff) ? 16'hffff : req_r.mtu_value[15:0];
    for (int i = ENTRIES-1; i >= 0; i--) begin
      if (live_r[i] && path_r[i]) begin
        tr_hit = 1'b1; tr_hit_i = IW'(i);
        pt_hit = 1'b1; pt_i = IW'(i);
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (!live_r[i]) begin
        tr_sel_ok = 1'b1; tr_sel_i = IW'(i); oldest = pmc_pkg::NoWake;
      end else if (e_mtu_r[i] == '0 && (!tr_sel_ok || age_r[i] > oldest)) begin
        tr_sel_ok = 1'b1; tr_sel_i = IW'(i); oldest = age_r[i];
      end
      if (live_r[i] && ifm_r[i] && dst_r[i] && e_mtu_r[i] != '0 && e_mtu_r[i] < best) begin
        best = e_mtu_r[i];
      end
    end
  end

  always_comb begin
    next = pmc_pkg::NoWake;
    left = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      left = {1'b0, timeout_ms} - age_c[i];
      if (live_c[i] && e_mtu_r[i] != '0 && left < next) next = left;
    end
  end

  assign q_take     = (state_r == S_IDLE) && !out_tvalid;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_take && q_valid) begin
            req_r <= q_req;
            res_r <= '0;
            if (q_req.drop || q_req.command > pmc_pkg::CMD_SWEEP) begin
              out_tvalid <= 1'b1;
            end else begin
              state_r <= S_MATCH;
            end
          end
        end
        S_MATCH: begin
          live_r  <= live_c;
          path_r  <= path_c;
          dst_r   <= dst_c;
          ifm_r   <= ifm_c;
          age_r   <= age_c;
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          state_r <= S_IDLE;
          case (req_r.command)
            pmc_pkg::CMD_TRACK: begin
              out_tvalid <= 1'b1;
              if (tr_hit) begin
                if (e_mtu_r[tr_hit_i] == '0) begin
                  e_st_r[tr_hit_i] <= req_r.now_ms;
                  res_r.status <= pmc_pkg::ST_REFRESHED;
                end else begin
                  res_r.status <= pmc_pkg::ST_KNOWN;
                end
              end else if (tr_sel_ok) begin
                valid_r[tr_sel_i] <= 1'b1;
                e_if_r[tr_sel_i]  <= req_r.iface;
                e_sh_r[tr_sel_i]  <= req_r.src_hi;
                e_sl_r[tr_sel_i]  <= req_r.src_lo;
                e_dh_r[tr_sel_i]  <= req_r.dst_hi;
                e_dl_r[tr_sel_i]  <= req_r.dst_lo;
                e_mtu_r[tr_sel_i] <= '0;
                e_st_r[tr_sel_i]  <= req_r.now_ms;
                res_r.status      <= pmc_pkg::ST_NEW_SLOT;
              end else begin
                res_r.status <= pmc_pkg::ST_NO_SLOT;
              end
            end
            pmc_pkg::CMD_PTB: begin
              if (!pt_hit) begin
                res_r.status <= pmc_pkg::ST_UNMATCHED;
                out_tvalid   <= 1'b1;
              end else if (e_mtu_r[pt_i] == '0 ||
                           req_r.mtu_value <= {16'd0, e_mtu_r[pt_i]}) begin
                e_mtu_r[pt_i] <= req_r.mtu_value[15:0];
                e_st_r[pt_i]  <= req_r.now_ms;
                res_r.status  <= pmc_pkg::ST_LEARNED;
                state_r       <= S_SWEEP;
              end else begin
                res_r.status <= pmc_pkg::ST_KNOWN;
                out_tvalid   <= 1'b1;
              end
            end
            pmc_pkg::CMD_LOOKUP: begin
              res_r.status   <= pmc_pkg::ST_DONE;
              res_r.path_mtu <= best;
              out_tvalid     <= 1'b1;
            end
            pmc_pkg::CMD_DROP: begin
              valid_r      <= valid_r & ~ifm_r;
              res_r.status <= pmc_pkg::ST_DONE;
              state_r      <= S_SWEEP;
            end
            default: begin
              res_r.status <= pmc_pkg::ST_DONE;
              state_r      <= S_SWEEP;
            end
          endcase
        end
        S_SWEEP: begin
          valid_r    <= live_c;
          out_tvalid <= 1'b1;
          state_r    <= S_IDLE;
          if (next != pmc_pkg::NoWake) begin
            res_r.wake_valid    <= 1'b1;
            res_r.wake_delay_ms <= next[30:0];
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[design/ipv6_path_mtu_cache.sv]
// Top level of the IPv6 path MTU cache: timeout register, front and back
// parts joined by a two-deep request queue. Depends on pmc_pkg, pmc_front, pmc_back.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | in_tdata, 360 bits of fields
//   out_    | out | out_tvalid/tready  | out_tdata, 51 bits of fields
//   cfg_    | in  | cfg_wr_en          | cfg_wr_data, timeout_ms
//
// Track and lookup pass through the match and apply steps of the back part;
// PTB with update, drop and sweep also pass through its sweep step.
// Reset clears the table valid bits and loads a timeout of 600000 ms.
// The front keeps taking requests while a result waits, until the queue fills.
module ipv6_path_mtu_cache #(
  parameter int unsigned ENTRIES    = pmc_pkg::DefEntries,
  parameter int unsigned NUM_IFACES = pmc_pkg::DefIfaces
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // command, iface, src_hi, src_lo, dst_hi, dst_lo, now_ms, mtu_value,
  // iface_mtu, quoted_payload_len, src_is_reply_target
  input  logic [pmc_pkg::InDataW-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // status, path_mtu, wake_valid, wake_delay_ms
  output logic [pmc_pkg::OutDataW-1:0] out_tdata,
  input  logic                         cfg_wr_en,
  input  logic [30:0]                  cfg_wr_data
);

  logic [30:0] timeout_r;
  logic q_valid, q_take;
  pmc_pkg::req_t q_req;
  pmc_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= pmc_pkg::TimeoutRst;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  pmc_front #(.NUM_IFACES(NUM_IFACES)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_valid, .q_take, .q_req
  );

  pmc_back #(.ENTRIES(ENTRIES)) u_back (
    .clk, .rst_n, .timeout_ms(timeout_r), .q_valid, .q_take, .q_req,
    .out_tvalid, .out_tready, .out_res(res)
  );

  assign out_tdata = {5'd0, res};

endmodule

[tb/ipv6_path_mtu_cache_test.sv]
// Self-checking testbench for the IPv6 path MTU cache: drives requests on the
// stream input, predicts each result with its own table model and checks it.
// Depends on pmc_pkg and ipv6_path_mtu_cache.
`timescale 1ns / 100ps

module ipv6_path_mtu_cache_test;

  localparam int NumSlots   = 8;
  localparam int PoolSize   = 10;
  localparam int IdleLimit  = 5000;

  typedef struct {
    logic [2:0]  command;
    logic [3:0]  iface;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [31:0] now_ms;
    logic [31:0] mtu_value;
    logic [15:0] iface_mtu;
    logic [15:0] payload_len;
    logic        reply_ok;
  } path_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] path_mtu;
    logic        wake_valid;
    logic [30:0] wake_delay_ms;
  } cache_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [pmc_pkg::InDataW-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [pmc_pkg::OutDataW-1:0] out_tdata;
  logic cfg_wr_en;
  logic [30:0] cfg_wr_data;

  ipv6_path_mtu_cache dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // predicted path table
  logic        slot_valid [NumSlots];
  logic [3:0]  slot_iface [NumSlots];
  logic [63:0] slot_src_hi [NumSlots];
  logic [63:0] slot_src_lo [NumSlots];
  logic [63:0] slot_dst_hi [NumSlots];
  logic [63:0] slot_dst_lo [NumSlots];
  logic [31:0] slot_stamp [NumSlots];
  logic [15:0] slot_mtu [NumSlots];
  logic [30:0] expiry_ms;

  // known paths the random traffic reuses
  logic [3:0]  pool_iface [PoolSize];
  logic [63:0] pool_src_hi [PoolSize];
  logic [63:0] pool_src_lo [PoolSize];
  logic [63:0] pool_dst_hi [PoolSize];
  logic [63:0] pool_dst_lo [PoolSize];

  cache_res_t pending_results [$];
  logic [31:0] clock_ms;
  int requests_sent;
  int results_seen;
  int mismatches;
  int idle_cycles;
  int stall_left;
  bit gaps_on;
  bit stalls_on;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [pmc_pkg::InDataW-1:0] pack_request(path_req_t r);
    return {r.reply_ok, r.payload_len, r.iface_mtu, r.mtu_value, r.now_ms,
            r.dst_lo, r.dst_hi, r.src_lo, r.src_hi, r.iface, r.command};
  endfunction

  function automatic logic [31:0] expire_slots(logic [31:0] now);
    logic [31:0] next;
    logic [31:0] age;
    next = pmc_pkg::NoWake;
    for (int i = 0; i < NumSlots; i++) begin
      if (slot_valid[i]) begin
        age = now - slot_stamp[i];
        if (age >= {1'b0, expiry_ms}) begin
          slot_valid[i] = 1'b0;
        end else if (slot_mtu[i] != 0 && ({1'b0, expiry_ms} - age) < next) begin
          next = {1'b0, expiry_ms} - age;
        end
      end
    end
    return next;
  endfunction

  function automatic bit slot_live(int i, logic [31:0] now);
    logic [31:0] age;
    age = now - slot_stamp[i];
    return slot_valid[i] && age < {1'b0, expiry_ms};
  endfunction

  function automatic bit slot_matches(int i, path_req_t r);
    return slot_iface[i] == r.iface && slot_src_hi[i] == r.src_hi &&
           slot_src_lo[i] == r.src_lo && slot_dst_hi[i] == r.dst_hi &&
           slot_dst_lo[i] == r.dst_lo;
  endfunction

  function automatic void set_wake(inout cache_res_t res, input logic [31:0] next);
    if (next != pmc_pkg::NoWake) begin
      res.wake_valid = 1'b1;
      res.wake_delay_ms = next[30:0];
    end
  endfunction

  function automatic cache_res_t predict_path_result(path_req_t r);
    cache_res_t res;
    int sel;
    logic [31:0] oldest;
    logic [31:0] age;
    logic [15:0] best;
    res = '{pmc_pkg::ST_IGNORED, 16'd0, 1'b0, 31'd0};
    case (r.command)
      pmc_pkg::CMD_TRACK: begin
        if (r.iface_mtu < pmc_pkg::MinLinkMtu) return res;
        if ((r.src_hi == 0 && r.src_lo == 0) || r.src_hi[63:56] == 8'hff) return res;
        sel = -1;
        oldest = 0;
        for (int i = 0; i < NumSlots; i++) begin
          age = r.now_ms - slot_stamp[i];
          if (!slot_live(i, r.now_ms)) begin
            sel = i;
            oldest = pmc_pkg::NoWake;
          end else if (slot_matches(i, r)) begin
            if (slot_mtu[i] == 0) begin
              slot_stamp[i] = r.now_ms;
              res.status = pmc_pkg::ST_REFRESHED;
            end else begin
              res.status = pmc_pkg::ST_KNOWN;
            end
            return res;
          end else if (slot_mtu[i] == 0 && (sel < 0 || age > oldest)) begin
            sel = i;
            oldest = age;
          end
        end
        if (sel < 0) begin
          res.status = pmc_pkg::ST_NO_SLOT;
          return res;
        end
        slot_valid[sel] = 1'b1;
        slot_iface[sel] = r.iface;
        slot_src_hi[sel] = r.src_hi;
        slot_src_lo[sel] = r.src_lo;
        slot_dst_hi[sel] = r.dst_hi;
        slot_dst_lo[sel] = r.dst_lo;
        slot_mtu[sel] = 16'd0;
        slot_stamp[sel] = r.now_ms;
        res.status = pmc_pkg::ST_NEW_SLOT;
      end
      pmc_pkg::CMD_PTB: begin
        if (r.mtu_value < pmc_pkg::MinLinkMtu || r.mtu_value >= {16'd0, r.iface_mtu} ||
            r.mtu_value >= pmc_pkg::HeaderLen + r.payload_len || !r.reply_ok) return res;
        res.status = pmc_pkg::ST_UNMATCHED;
        for (int i = 0; i < NumSlots; i++) begin
          if (slot_live(i, r.now_ms) && slot_matches(i, r)) begin
            if (slot_mtu[i] == 0 || r.mtu_value <= {16'd0, slot_mtu[i]}) begin
              slot_mtu[i] = r.mtu_value[15:0];
              slot_stamp[i] = r.now_ms;
              res.status = pmc_pkg::ST_LEARNED;
              set_wake(res, expire_slots(r.now_ms));
            end else begin
              res.status = pmc_pkg::ST_KNOWN;
            end
            break;
          end
        end
      end
      pmc_pkg::CMD_LOOKUP: begin
        best = (r.mtu_value > 32'hffff) ? 16'hffff : r.mtu_value[15:0];
        for (int i = 0; i < NumSlots; i++) begin
          if (slot_live(i, r.now_ms) && slot_iface[i] == r.iface && slot_mtu[i] != 0 &&
              slot_dst_hi[i] == r.dst_hi && slot_dst_lo[i] == r.dst_lo &&
              slot_mtu[i] < best)
            best = slot_mtu[i];
        end
        res.status = pmc_pkg::ST_DONE;
        res.path_mtu = best;
      end
      pmc_pkg::CMD_DROP: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (slot_valid[i] && slot_iface[i] == r.iface) slot_valid[i] = 1'b0;
        end
        res.status = pmc_pkg::ST_DONE;
        set_wake(res, expire_slots(r.now_ms));
      end
      pmc_pkg::CMD_SWEEP: begin
        res.status = pmc_pkg::ST_DONE;
        set_wake(res, expire_slots(r.now_ms));
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input path_req_t r);
    int gap;
    in_tdata <= pack_request(r);
    in_tvalid <= 1'b1;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    pending_results.push_back(predict_path_result(r));
    requests_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [30:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    expiry_ms = value;
  endtask

  function automatic path_req_t base_request(logic [2:0] cmd, int p);
    path_req_t r;
    r.command = cmd;
    r.iface = pool_iface[p];
    r.src_hi = pool_src_hi[p];
    r.src_lo = pool_src_lo[p];
    r.dst_hi = pool_dst_hi[p];
    r.dst_lo = pool_dst_lo[p];
    r.now_ms = clock_ms;
    r.mtu_value = 32'd1500;
    r.iface_mtu = 16'd9000;
    r.payload_len = 16'd8000;
    r.reply_ok = 1'b1;
    return r;
  endfunction

  task automatic refill_pool();
    for (int p = 0; p < PoolSize; p++) begin
      pool_iface[p] = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 1));
      pool_src_hi[p] = {$urandom, $urandom};
      if (pool_src_hi[p][63:56] == 8'hff) pool_src_hi[p][63:56] = 8'h20;
      pool_src_lo[p] = {$urandom, $urandom};
      pool_dst_hi[p] = {$urandom, $urandom};
      pool_dst_lo[p] = (p != 0 && $urandom_range(0, 2) == 0) ? pool_dst_lo[0] :
                       {$urandom, $urandom};
    end
    for (int p = 1; p < PoolSize; p += 3) pool_dst_hi[p] = pool_dst_hi[0];
  endtask

  function automatic path_req_t random_request();
    path_req_t r;
    int w;
    int lim;
    r = base_request(pmc_pkg::CMD_TRACK, $urandom_range(0, PoolSize - 1));
    w = $urandom_range(0, 99);
    if (w < 35) r.command = pmc_pkg::CMD_TRACK;
    else if (w < 63) r.command = pmc_pkg::CMD_PTB;
    else if (w < 78) r.command = pmc_pkg::CMD_LOOKUP;
    else if (w < 83) r.command = pmc_pkg::CMD_DROP;
    else if (w < 93) r.command = pmc_pkg::CMD_SWEEP;
    else r.command = 3'($urandom_range(5, 7));
    r.iface_mtu = 16'($urandom_range(1281, 65535));
    r.payload_len = 16'($urandom_range(1241, 65535));
    lim = r.iface_mtu - 1;
    if (r.payload_len + 39 < lim) lim = r.payload_len + 39;
    r.mtu_value = $urandom_range(1280, ($urandom_range(0, 1) == 1) ? 1600 : lim);
    if (r.command == pmc_pkg::CMD_LOOKUP)
      r.mtu_value = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1280, 65535);
    if ($urandom_range(0, 9) == 0) begin
      r.iface = 4'($urandom);
      r.src_hi = {$urandom, $urandom};
      r.src_lo = {$urandom, $urandom};
      r.dst_hi = {$urandom, $urandom};
      r.dst_lo = {$urandom, $urandom};
      r.mtu_value = $urandom;
      r.iface_mtu = 16'($urandom);
      r.payload_len = 16'($urandom);
      r.reply_ok = 1'($urandom);
    end else if ($urandom_range(0, 19) == 0) begin
      r.src_hi[63:56] = 8'hff;
    end else if ($urandom_range(0, 19) == 0) begin
      r.reply_ok = 1'b0;
    end
    return r;
  endfunction

  task automatic advance_clock();
    int w;
    w = $urandom_range(0, 99);
    if (w < 70) clock_ms += $urandom_range(0, 500);
    else if (w < 90) clock_ms += $urandom_range(0, 50000);
    else if (w < 98) clock_ms += $urandom_range(expiry_ms / 2, expiry_ms + 1000);
    else clock_ms += $urandom;
  endtask

  task automatic test_track_filters();
    path_req_t r;
    r = base_request(pmc_pkg::CMD_TRACK, 0);
    r.iface_mtu = 16'd1279;
    send_request(r);
    r = base_request(pmc_pkg::CMD_TRACK, 0);
    r.src_hi = 64'd0;
    r.src_lo = 64'd0;
    send_request(r);
    r = base_request(pmc_pkg::CMD_TRACK, 0);
    r.src_hi = 64'hff02_0000_0000_0000;
    send_request(r);
    r = base_request(pmc_pkg::CMD_TRACK, 0);
    r.src_hi = 64'hffff_ffff_ffff_ffff;
    r.src_lo = 64'hffff_ffff_ffff_ffff;
    r.iface = 4'hf;
    r.iface_mtu = 16'hffff;
    send_request(r);
  endtask

  task automatic test_table_fill();
    for (int p = 0; p < 9; p++) begin
      clock_ms += 10;
      send_request(base_request(pmc_pkg::CMD_TRACK, p));
    end
    clock_ms += 10;
    send_request(base_request(pmc_pkg::CMD_TRACK, 8));
  endtask

  task automatic test_ptb_rules();
    path_req_t r;
    r = base_request(pmc_pkg::CMD_PTB, 8);
    r.mtu_value = 32'd1279;
    send_request(r);
    r = base_request(pmc_pkg::CMD_PTB, 8);
    r.mtu_value = 32'd9000;
    send_request(r);
    r = base_request(pmc_pkg::CMD_PTB, 8);
    r.payload_len = 16'd1460;
    send_request(r);
    r = base_request(pmc_pkg::CMD_PTB, 8);
    r.reply_ok = 1'b0;
    send_request(r);
    send_request(base_request(pmc_pkg::CMD_PTB, 8));
    r = base_request(pmc_pkg::CMD_PTB, 8);
    r.mtu_value = 32'd1280;
    send_request(r);
    send_request(base_request(pmc_pkg::CMD_PTB, 8));
    r = base_request(pmc_pkg::CMD_PTB, 8);
    r.src_lo = ~r.src_lo;
    send_request(r);
  endtask

  task automatic test_lookup_drop_sweep();
    path_req_t r;
    r = base_request(pmc_pkg::CMD_LOOKUP, 8);
    r.mtu_value = 32'hffff_ffff;
    send_request(r);
    r.mtu_value = 32'd0;
    send_request(r);
    send_request(base_request(pmc_pkg::CMD_SWEEP, 8));
    send_request(base_request(pmc_pkg::CMD_DROP, 8));
    for (int c = 5; c < 8; c++) send_request(base_request(3'(c), 0));
  endtask

  task automatic test_random_traffic(input logic [30:0] timeout_value, input int count);
    write_timeout(timeout_value);
    refill_pool();
    gaps_on = $urandom_range(0, 3) != 0;
    stalls_on = $urandom_range(0, 3) != 0;
    for (int n = 0; n < count; n++) begin
      advance_clock();
      send_request(random_request());
      if (n % 40 == 39) begin
        gaps_on = !gaps_on;
        stalls_on = $urandom_range(0, 1);
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cache_res_t want;
    cache_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[2:0], out_tdata[18:3], out_tdata[19], out_tdata[50:20]};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected %p, got %p", results_seen, want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no progress, %0d results outstanding", pending_results.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    out_tready <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    requests_sent = 0;
    results_seen = 0;
    mismatches = 0;
    idle_cycles = 0;
    stall_left = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    clock_ms = 32'd1000;
    expiry_ms = pmc_pkg::TimeoutRst;
    for (int i = 0; i < NumSlots; i++) slot_valid[i] = 1'b0;
    refill_pool();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_track_filters();
    test_table_fill();
    test_ptb_rules();
    test_lookup_drop_sweep();
    test_random_traffic(31'd300000, 115);
    clock_ms = 32'hfffe_0000;
    test_random_traffic(31'h7fffffff, 110);
    test_random_traffic(pmc_pkg::TimeoutRst, 115);
    test_random_traffic(31'($urandom_range(300001, 32'h7ffffffe)), 110);
    drain_results();
    $display("covered %0d requests and %0d results across four timeout settings,",
             requests_sent, results_seen);
    $display("including clock wrap, expiry, eviction and PTB filtering");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
